### src/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types of the promotable priority table: command and status codes,
// and the control bundle that drives the max-search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_PROMOTE = 3'd1,
    MODE_POP     = 3'd2,
    MODE_PEEK    = 3'd3,
    MODE_READ    = 3'd4
  } ppt_mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BADID = 2'd2,
    ST_EMPTY = 2'd3
  } ppt_status_e;

  // Control of the max-search unit: clear the running best, and an entry
  // arriving from the table this cycle.
  typedef struct packed {
    logic clr;
    logic vld;
  } ppt_scan_ctrl_t;

endpackage

`default_nettype wire

### src/ppt_scan.sv
// ----------------------------------------------------------------------------
// ppt_scan
// Running max search: one comparator that folds one table entry per cycle,
// while vld is high, into the best entry so far; ties go to the later (larger) id.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_scan import ppt_pkg::*; #(
  parameter int unsigned CAPACITY       = 64,
  parameter int unsigned PAYLOAD_WIDTH  = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ppt_scan_ctrl_t             ctrl_i,
  input  wire logic [$clog2(CAPACITY)-1:0] idx_i,
  input  wire logic                       live_i,
  input  wire logic [PRIORITY_WIDTH-1:0]  pri_i,
  input  wire logic [PAYLOAD_WIDTH-1:0]   pay_i,
  output logic                            found_o,
  output logic [$clog2(CAPACITY)-1:0]     best_idx_o,
  output logic [PRIORITY_WIDTH-1:0]       best_pri_o,
  output logic [PAYLOAD_WIDTH-1:0]        best_pay_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic                      found_q, found_d;
  logic [IDX_W-1:0]          idx_q;
  logic [PRIORITY_WIDTH-1:0] pri_q;
  logic [PAYLOAD_WIDTH-1:0]  pay_q;
  logic                      take;

  // Take the entry when live and not below the best so far.
  assign take = ctrl_i.vld && live_i && (!found_q || (pri_i >= pri_q));

  always_comb begin
    found_d = found_q;
    if (ctrl_i.clr) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clr) begin
      idx_q <= idx_i;
      pri_q <= pri_i;
      pay_q <= pay_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = idx_q;
  assign best_pri_o = pri_q;
  assign best_pay_o = pay_q;

endmodule

`default_nettype wire

### src/promotable_priority_table_top.sv
// ----------------------------------------------------------------------------
// promotable_priority_table_top
// Table of payload entries with priorities; add, promote, pop max, peek max
// and read, served by one table read port, one write port and one shared max-search comparator.
// ----------------------------------------------------------------------------
// Reports: add, unused modes, bad ids and pop or peek before any add report
//   in the cycle after the item is accepted; promote and read of an added id pass S_ACCESS first.
// Pop and peek walk the ids added so far, one per cycle through one
//   comparator, then report from S_FINISH. busy is high until the report
//   cycle, so the next item can go in at the edge that takes the report.
// Reset clears the add counter and the sequencer; table contents need none.
`default_nettype none

module promotable_priority_table_top import ppt_pkg::*; #(
  parameter int unsigned CAPACITY       = 64,
  parameter int unsigned PAYLOAD_WIDTH  = 32,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode_i,
  input  wire logic [5:0]  entry_id_i,
  input  wire logic [31:0] payload_in_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [5:0]       result_id_o,
  output logic [31:0]      payload_out_o,
  output logic [15:0]      priority_out_o,
  output logic             entry_live_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;
  localparam int unsigned MEM_W = 1 + PRIORITY_WIDTH + PAYLOAD_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  // Sequencer and command registers
  state_e            state_q, state_d;
  ppt_mode_e         mode_q, mode_d;
  logic [5:0]        id_q, id_d;
  logic [CNT_W-1:0]  next_free_q, next_free_d;

  // Scan address generator and read pipeline tag
  logic [IDX_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic              issuing_q, issuing_d;
  logic              rd_vld_q, rd_vld_d;
  logic              rd_last_q, rd_last_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;

  // Result registers
  logic              done_q, done_d;
  ppt_status_e       status_q, status_d;
  logic [5:0]        rid_q, rid_d;
  logic [31:0]       pay_out_q, pay_out_d;
  logic [15:0]       pri_out_q, pri_out_d;
  logic              live_q, live_d;

  // Table: {live, priority, payload} per id
  logic [MEM_W-1:0]  mem [CAPACITY];
  logic [MEM_W-1:0]  rdata_q;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [MEM_W-1:0]  wdata;
  logic [IDX_W-1:0]  raddr;

  logic                      rd_live;
  logic [PRIORITY_WIDTH-1:0] rd_pri;
  logic [PAYLOAD_WIDTH-1:0]  rd_pay;
  logic [PRIORITY_WIDTH-1:0] pri_inc;

  logic [CMP_W-1:0]  id_in_ext;
  logic [CMP_W-1:0]  id_q_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              id_exists;
  logic              table_full;
  logic              accept;

  ppt_scan_ctrl_t            scan_ctrl;
  logic                      best_found;
  logic [IDX_W-1:0]          best_idx;
  logic [PRIORITY_WIDTH-1:0] best_pri;
  logic [PAYLOAD_WIDTH-1:0]  best_pay;

  assign accept     = start && (state_q == S_IDLE);
  assign busy       = (state_q != S_IDLE);

  assign id_in_ext  = CMP_W'(entry_id_i);
  assign id_q_ext   = CMP_W'(id_q);
  assign cnt_ext    = CMP_W'(next_free_q);
  assign id_exists  = id_in_ext < cnt_ext;
  assign table_full = (next_free_q == CNT_W'(CAPACITY));

  assign rd_live = rdata_q[MEM_W-1];
  assign rd_pri  = rdata_q[MEM_W-2 -: PRIORITY_WIDTH];
  assign rd_pay  = rdata_q[PAYLOAD_WIDTH-1:0];
  // Saturate at the all-ones priority
  assign pri_inc = (rd_pri == {PRIORITY_WIDTH{1'b1}}) ? rd_pri : rd_pri + 1'b1;

  // Read port: addressed id while idle, scan counter otherwise
  assign raddr = (state_q == S_IDLE) ? id_in_ext[IDX_W-1:0] : scan_cnt_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign scan_ctrl.clr = accept && ((mode_i == MODE_POP) || (mode_i == MODE_PEEK));
  assign scan_ctrl.vld = rd_vld_q;

  ppt_scan #(
    .CAPACITY       (CAPACITY),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .idx_i      (rd_idx_q),
    .live_i     (rd_live),
    .pri_i      (rd_pri),
    .pay_i      (rd_pay),
    .found_o    (best_found),
    .best_idx_o (best_idx),
    .best_pri_o (best_pri),
    .best_pay_o (best_pay)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    id_d        = id_q;
    next_free_d = next_free_q;
    scan_cnt_d  = scan_cnt_q;
    issuing_d   = 1'b0;
    rd_vld_d    = 1'b0;
    rd_last_d   = 1'b0;
    rd_idx_d    = scan_cnt_q;
    done_d      = 1'b0;
    status_d    = ST_OK;
    rid_d       = '0;
    pay_out_d   = '0;
    pri_out_d   = '0;
    live_d      = 1'b0;
    we          = 1'b0;
    waddr       = best_idx;
    wdata       = {1'b0, best_pri, best_pay};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d = ppt_mode_e'(mode_i);
          id_d   = entry_id_i;
          unique case (mode_i) inside
            MODE_ADD: begin
              done_d = 1'b1;
              if (table_full) begin
                status_d = ST_FULL;
              end else begin
                // Store at priority 0 under the next unused id
                we          = 1'b1;
                waddr       = next_free_q[IDX_W-1:0];
                wdata       = {1'b1, {PRIORITY_WIDTH{1'b0}},
                               PAYLOAD_WIDTH'(payload_in_i)};
                next_free_d = next_free_q + 1'b1;
                rid_d       = 6'(next_free_q);
                live_d      = 1'b1;
              end
            end
            MODE_PROMOTE, MODE_READ: begin
              if (id_exists) begin
                state_d = S_ACCESS;
              end else begin
                done_d   = 1'b1;
                status_d = ST_BADID;
                rid_d    = entry_id_i;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (next_free_q == '0) begin
                done_d   = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                state_d    = S_SCAN;
                scan_cnt_d = '0;
                issuing_d  = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_ACCESS: begin
        done_d  = 1'b1;
        rid_d   = id_q;
        state_d = S_IDLE;
        if (mode_q == MODE_PROMOTE) begin
          if (rd_live) begin
            we        = 1'b1;
            waddr     = id_q_ext[IDX_W-1:0];
            wdata     = {1'b1, pri_inc, rd_pay};
            pay_out_d = 32'(rd_pay);
            pri_out_d = 16'(pri_inc);
            live_d    = 1'b1;
          end else begin
            status_d = ST_BADID;
          end
        end else if (rd_live) begin
          pay_out_d = 32'(rd_pay);
          pri_out_d = 16'(rd_pri);
          live_d    = 1'b1;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle up to the last added id
        if (issuing_q) begin
          rd_vld_d  = 1'b1;
          rd_idx_d  = scan_cnt_q;
          rd_last_d = (CNT_W'(scan_cnt_q) + 1'b1) == next_free_q;
          if (rd_last_d) begin
            issuing_d = 1'b0;
          end else begin
            issuing_d  = 1'b1;
            scan_cnt_d = scan_cnt_q + 1'b1;
          end
        end
        // Last entry folds into the best at this edge
        if (rd_vld_q && rd_last_q) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (best_found) begin
          rid_d     = 6'(best_idx);
          pay_out_d = 32'(best_pay);
          pri_out_d = 16'(best_pri);
          live_d    = 1'b1;
          // Drop the winner on pop
          if (mode_q == MODE_POP) begin
            we = 1'b1;
          end
        end else begin
          status_d = ST_EMPTY;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_free_q <= '0;
      issuing_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      issuing_q   <= issuing_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    id_q       <= id_d;
    scan_cnt_q <= scan_cnt_d;
    rd_idx_q   <= rd_idx_d;
    status_q   <= status_d;
    rid_q      <= rid_d;
    pay_out_q  <= pay_out_d;
    pri_out_q  <= pri_out_d;
    live_q     <= live_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign result_id_o    = rid_q;
  assign payload_out_o  = pay_out_q;
  assign priority_out_o = pri_out_q;
  assign entry_live_o   = live_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for promotable_priority_table_top. Each accepted item
// updates a private copy of the table and predicts its report; the report
// monitor compares every done_o strobe against the oldest prediction. Runs a
// short directed sweep, a long promote run on one entry, then a weighted
// random mix with bursty sender gaps.
// ----------------------------------------------------------------------------

module tb_top;
  import ppt_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned PAY_BITS      = 32;
  localparam int unsigned PRIO_BITS     = 16;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned RANDOM_ITEMS  = 1165;
  // Keep the last stretch of the random run free of sender gaps.
  localparam int unsigned TAIL_ITEMS    = 150;
  // Leave room after the last report for any stray strobe.
  localparam int unsigned DRAIN_CYCLES  = TABLE_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned MAX_SHOWN     = 10;

  localparam bit [PRIO_BITS-1:0] PRIO_CEILING = '1;
  // Mode encodings left unused by the block.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'(MODE_READ + 1);
  localparam logic [2:0] MODE_SPARE_LAST  = 3'h7;
  // Promotes piled onto a single entry.
  localparam int unsigned CHAIN_PROMOTES = 60;

  typedef struct {
    ppt_status_e          status;
    logic [5:0]           id;
    logic [PAY_BITS-1:0]  payload;
    logic [PRIO_BITS-1:0] prio;
    logic                 live;
  } report_t;

  // --------------------------------------------------------------------------
  // Table shadow: mirrors the entry store, predicts one report per accepted
  // item and checks each strobed report against the oldest prediction.
  // --------------------------------------------------------------------------
  class table_tracker;
    bit [PAY_BITS-1:0]  slot_payload [TABLE_DEPTH];
    bit [PRIO_BITS-1:0] slot_prio    [TABLE_DEPTH];
    bit                 slot_live    [TABLE_DEPTH];
    int unsigned        added;
    int unsigned        fail_count;
    report_t            awaited [$];

    function void push_report(ppt_status_e st, logic [5:0] id,
                              logic [PAY_BITS-1:0] pay,
                              logic [PRIO_BITS-1:0] pri, logic live);
      report_t r;
      r.status  = st;
      r.id      = id;
      r.payload = pay;
      r.prio    = pri;
      r.live    = live;
      awaited.insert(awaited.size(), r);
    endfunction

    // Apply one accepted item to the shadow and queue its report.
    function void note_command(logic [2:0] op, logic [5:0] id,
                               logic [PAY_BITS-1:0] pay);
      bit          known;
      bit          found;
      int unsigned best;
      known = (id < added);
      case (op) inside
        MODE_ADD: begin
          if (added >= TABLE_DEPTH) begin
            push_report(ST_FULL, '0, '0, '0, 1'b0);
          end else begin
            slot_payload[added] = pay;
            slot_prio[added]    = '0;
            slot_live[added]    = 1'b1;
            push_report(ST_OK, 6'(added), '0, '0, 1'b1);
            added++;
          end
        end
        MODE_PROMOTE: begin
          if (!known || !slot_live[id]) begin
            push_report(ST_BADID, id, '0, '0, 1'b0);
          end else begin
            // Saturate at the ceiling.
            if (slot_prio[id] != PRIO_CEILING) slot_prio[id]++;
            push_report(ST_OK, id, slot_payload[id], slot_prio[id], 1'b1);
          end
        end
        MODE_POP, MODE_PEEK: begin
          found = 1'b0;
          best  = 0;
          // Ties go to the larger id, hence >= while walking upward.
          for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_live[i] && (!found || slot_prio[i] >= slot_prio[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (!found) begin
            push_report(ST_EMPTY, '0, '0, '0, 1'b0);
          end else begin
            push_report(ST_OK, 6'(best), slot_payload[best], slot_prio[best], 1'b1);
            if (op == MODE_POP) slot_live[best] = 1'b0;
          end
        end
        MODE_READ: begin
          if (!known) begin
            push_report(ST_BADID, id, '0, '0, 1'b0);
          end else if (!slot_live[id]) begin
            push_report(ST_OK, id, '0, '0, 1'b0);
          end else begin
            push_report(ST_OK, id, slot_payload[id], slot_prio[id], 1'b1);
          end
        end
        default: begin
          push_report(ST_OK, '0, '0, '0, 1'b0);
        end
      endcase
    endfunction

    // Compare one strobed report with the oldest prediction.
    function void check_report(logic [1:0] st, logic [5:0] id,
                               logic [PAY_BITS-1:0] pay,
                               logic [PRIO_BITS-1:0] pri, logic live);
      report_t want;
      if (awaited.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("[%0t] unexpected report: status %0d id %0d payload %h prio %0d live %b",
                   $time, st, id, pay, pri, live);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || id !== want.id || pay !== want.payload ||
          pri !== want.prio || live !== want.live) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
          $display("[%0t] report mismatch", $time);
          $display("  expected: status %0d id %0d payload %h prio %0d live %b",
                   want.status, want.id, want.payload, want.prio, want.live);
          $display("  actual:   status %0d id %0d payload %h prio %0d live %b",
                   st, id, pay, pri, live);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input is known from time zero.
  // --------------------------------------------------------------------------
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 start        = 1'b0;
  logic [2:0]           mode_i       = MODE_ADD;
  logic [5:0]           entry_id_i   = '0;
  logic [PAY_BITS-1:0]  payload_in_i = '0;
  logic                 busy;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [5:0]           result_id_o;
  logic [PAY_BITS-1:0]  payload_out_o;
  logic [PRIO_BITS-1:0] priority_out_o;
  logic                 entry_live_o;

  table_tracker tracker;
  int unsigned  cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  promotable_priority_table_top #(
    .CAPACITY      (TABLE_DEPTH),
    .PAYLOAD_WIDTH (PAY_BITS),
    .PRIORITY_WIDTH(PRIO_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .entry_id_i    (entry_id_i),
    .payload_in_i  (payload_in_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .payload_out_o (payload_out_o),
    .priority_out_o(priority_out_o),
    .entry_live_o  (entry_live_o)
  );

  // Sample the strobe at the edge that closes its cycle; the receiver never
  // stalls, so every strobe is a report.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      tracker.check_report(status_o, result_id_o, payload_out_o, priority_out_o,
                           entry_live_o);
  end

  // --------------------------------------------------------------------------
  // Sender side. Call these at a rising edge only.
  // --------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. start stays high
  // on return, so a following item goes out back to back.
  task automatic send_item(input logic [2:0] op, input logic [5:0] id,
                           input logic [PAY_BITS-1:0] pay);
    start        <= 1'b1;
    mode_i       <= op;
    entry_id_i   <= id;
    payload_in_i <= pay;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.note_command(op, id, pay);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Extremes, every mode and the bad-id and empty error paths on a fresh table.
  task automatic run_directed();
    send_item(MODE_PEEK,    6'd0,  '0);   // empty table
    send_item(MODE_POP,     6'd0,  '0);   // empty table
    send_item(MODE_PROMOTE, 6'd0,  '0);   // id never added
    send_item(MODE_READ,    6'd63, '1);   // id never added, top id
    send_item(MODE_SPARE_FIRST, 6'd63, '1);
    send_item(3'(MODE_SPARE_FIRST + 1), 6'd21, 32'hA5A5_5A5A);
    send_item(MODE_SPARE_LAST,  6'd42, 32'h5A5A_A5A5);
    send_item(MODE_ADD,     6'd63, '0);   // id 0, all-zero payload
    send_item(MODE_ADD,     6'd0,  '1);   // id 1, all-ones payload
    send_item(MODE_PEEK,    6'd0,  '0);   // tie at zero: larger id wins
    send_item(MODE_PROMOTE, 6'd0,  '0);
    send_item(MODE_PEEK,    6'd0,  '0);   // id 0 now ahead
    send_item(MODE_PROMOTE, 6'd1,  '0);
    send_item(MODE_PEEK,    6'd0,  '0);   // tie again: id 1
    send_item(MODE_POP,     6'd0,  '0);
    send_item(MODE_READ,    6'd1,  '0);   // popped entry reads as dead
    send_item(MODE_PROMOTE, 6'd1,  '0);   // popped entry cannot promote
    send_item(MODE_READ,    6'd0,  '0);
    send_item(MODE_READ,    6'd2,  '0);   // just past the last add
    send_item(MODE_PEEK,    6'd0,  '0);
  endtask

  // Pile a run of promotes onto one fresh entry, then read, peek and pop it.
  task automatic run_promote_chain();
    logic [5:0] chain_id;
    chain_id = 6'(tracker.added);
    send_item(MODE_ADD, chain_id, $urandom());
    for (int unsigned k = 0; k < CHAIN_PROMOTES; k++)
      send_item(MODE_PROMOTE, chain_id, $urandom());
    send_item(MODE_READ, chain_id, '0);
    send_item(MODE_PEEK, chain_id, '0);
    send_item(MODE_POP,  chain_id, '0);
    send_item(MODE_READ, chain_id, '0);
  endtask

  // Weighted mix: mostly promotes and reads aimed at added ids, enough adds
  // to fill the table early, and pops slow enough that it drains only near
  // the end of the run.
  task automatic run_random(input int unsigned count);
    int unsigned         roll;
    bit                  idle_on;
    logic [2:0]          op;
    logic [5:0]          id;
    logic [PAY_BITS-1:0] pay;
    idle_on = 1'b0;
    for (int unsigned n = 0; n < count; n++) begin
      // Re-decide gap density per block of items; keep the tail gap-free.
      if (n % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (idle_on && n + TAIL_ITEMS < count && $urandom_range(0, 4) == 0)
        pause($urandom_range(1, 18));

      case ($urandom_range(0, 15))
        0:       pay = '0;
        1:       pay = '1;
        default: pay = $urandom();
      endcase

      id = 6'($urandom_range(0, TABLE_DEPTH - 1));
      roll = $urandom_range(0, 99);
      if (roll < 15)      op = MODE_ADD;
      else if (roll < 64) op = MODE_PROMOTE;
      else if (roll < 78) op = MODE_READ;
      else if (roll < 88) op = MODE_PEEK;
      else if (roll < 93) op = MODE_POP;
      else                op = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));

      // Aim most promotes and reads at ids that exist.
      if ((op == MODE_PROMOTE || op == MODE_READ) && tracker.added != 0 &&
          $urandom_range(0, 99) < 85)
        id = 6'($urandom_range(0, tracker.added - 1));

      send_item(op, id, pay);
    end
  endtask

  // --------------------------------------------------------------------------
  // Run sequence: reset once, directed sweep, promote run, random mix, drain.
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_promote_chain();
    run_random(RANDOM_ITEMS);
    start <= 1'b0;

    // Wait out every outstanding report, then watch for strays.
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.fail_count == 0 && tracker.awaited.size() == 0) begin
      $display("promotable_priority_table_top test passed");
    end else begin
      $display("promotable_priority_table_top test failed");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("promotable_priority_table_top test failed");
    $finish;
  end

endmodule

### promotable_priority_table_top.f
src/ppt_pkg.sv
src/ppt_scan.sv
src/promotable_priority_table_top.sv
tb/tb_top.sv
